>>> rtl/crps_pkg.sv
// crps_pkg: shared constants and types of the catmull-rom point and slope core
`timescale 1ns / 1ps
`default_nettype none
package crps_pkg;

   localparam int MaxPoints   = 64;
   localparam int IdxBits     = $clog2(MaxPoints);
   localparam int CountBits   = 7;
   localparam int FracBits    = 16;
   localparam int PosBits     = 23;
   localparam int CoordBits   = 32;
   localparam int TBits       = FracBits + 1;
   localparam int WeightBits  = 22;
   localparam int ProdBits    = CoordBits + WeightBits;
   localparam int AccBits     = ProdBits + 2;
   localparam int CsrIdxBits  = 8;
   localparam int QueueDepth  = 4;
   localparam int QPtrBits    = $clog2(QueueDepth);

   // action codes
   localparam logic ActLoad = 1'b0;
   localparam logic ActEval = 1'b1;

   // status codes
   localparam logic [1:0] StatOk    = 2'd0;
   localparam logic [1:0] StatFew   = 2'd1;
   localparam logic [1:0] StatClamp = 2'd2;

   // register indexes
   localparam logic [CsrIdxBits-1:0] CsrClosedMode = 8'd0;
   localparam logic [CsrIdxBits-1:0] CsrPointCount = 8'd1;

   typedef struct packed {
      logic                 closed;
      logic [CountBits-1:0] count;
   } crps_cfg_type;

   // one word between front and back
   typedef struct packed {
      logic                        is_load;
      logic [IdxBits-1:0]          slot;
      logic signed [CoordBits-1:0] px;
      logic signed [CoordBits-1:0] py;
      logic [IdxBits-1:0]          ix0;
      logic [IdxBits-1:0]          ix1;
      logic [IdxBits-1:0]          ix2;
      logic [IdxBits-1:0]          ix3;
      logic                        few;
      logic                        one_pt;
      logic [TBits-1:0]            t;
      logic [TBits-1:0]            tt;
      logic [TBits-1:0]            ttt;
      logic [1:0]                  status;
   } crps_word_type;

endpackage
`default_nettype wire

>>> rtl/crps_if.sv
// crps_if: valid/ready channel interfaces for request, response and csr
`timescale 1ns / 1ps
`default_nettype none
interface crps_req_if;
   logic                                  valid;
   logic                                  ready;
   logic                                  action;
   logic [crps_pkg::IdxBits-1:0]          point_index;
   logic signed [crps_pkg::CoordBits-1:0] point_x;
   logic signed [crps_pkg::CoordBits-1:0] point_y;
   logic [crps_pkg::PosBits-1:0]          position;
   modport source (output valid, action, point_index, point_x, point_y, position,
                   input ready);
   modport sink   (input valid, action, point_index, point_x, point_y, position,
                   output ready);
endinterface

interface crps_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [crps_pkg::CoordBits-1:0] curve_x;
   logic signed [crps_pkg::CoordBits-1:0] curve_y;
   logic signed [crps_pkg::CoordBits-1:0] slope_x;
   logic signed [crps_pkg::CoordBits-1:0] slope_y;
   logic [1:0]                            status;
   modport source (output valid, curve_x, curve_y, slope_x, slope_y, status,
                   input ready);
   modport sink   (input valid, curve_x, curve_y, slope_x, slope_y, status,
                   output ready);
endinterface

interface crps_csr_if;
   logic                              valid;
   logic                              ready;
   logic [crps_pkg::CsrIdxBits-1:0]   index;
   logic [crps_pkg::CountBits-1:0]    data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> rtl/crps_front.sv
// crps_front: accepts words, classifies loads and evaluates, computes t powers
`timescale 1ns / 1ps
`default_nettype none
module crps_front (
   input  wire                  clock,
   input  wire                  reset,
   crps_req_if.sink             req,
   input  crps_pkg::crps_cfg_type cfg,
   output logic                 word_valid,
   output crps_pkg::crps_word_type word,
   input  wire                  word_ready
);

   localparam int Ib = crps_pkg::IdxBits;
   localparam int Cb = crps_pkg::CountBits;
   localparam int Tb = crps_pkg::TBits;
   localparam int Fb = crps_pkg::FracBits;

   logic s1_valid_ff, s2_valid_ff, s3_valid_ff;
   crps_pkg::crps_word_type s1_ff, s2_ff, s3_ff;
   crps_pkg::crps_word_type s1_in, s2_in, s3_in;
   logic advance;

   logic [Cb-1:0]                 n, nseg;
   logic [crps_pkg::PosBits-1:0]  limit, pos;
   logic [Cb-1:0]                 seg7;
   logic [Ib-1:0]                 seg;
   logic [Tb-1:0]                 t;
   logic [Cb-1:0]                 sp1, sp2;
   logic [2*Tb-1:0]               sq, cube;

   assign advance    = !s3_valid_ff || word_ready;
   assign req.ready  = advance;
   assign word_valid = s3_valid_ff;
   assign word       = s3_ff;

   // classify and locate the segment
   always_comb begin
      n = (cfg.count > Cb'(crps_pkg::MaxPoints)) ? Cb'(crps_pkg::MaxPoints) : cfg.count;
      nseg  = cfg.closed ? n : n - Cb'(1);
      limit = {nseg, {Fb{1'b0}}};
      pos   = req.position;
      s1_in = '0;
      s1_in.is_load = (req.action == crps_pkg::ActLoad);
      s1_in.slot    = req.point_index;
      s1_in.px      = req.point_x;
      s1_in.py      = req.point_y;
      s1_in.status  = crps_pkg::StatOk;
      if (pos > limit) begin
         pos = limit;
         s1_in.status = crps_pkg::StatClamp;
      end
      seg7 = pos[crps_pkg::PosBits-1:Fb];
      t    = {1'b0, pos[Fb-1:0]};
      if (seg7 >= nseg) begin
         seg7 = nseg - Cb'(1);
         t    = Tb'(1) << Fb;
      end
      seg = seg7[Ib-1:0];
      sp1 = {1'b0, seg} + Cb'(1);
      sp2 = {1'b0, seg} + Cb'(2);
      s1_in.ix1 = seg;
      if (cfg.closed) begin
         s1_in.ix0 = (seg == '0) ? Ib'(n - Cb'(1)) : seg - Ib'(1);
         s1_in.ix2 = (sp1 >= n) ? Ib'(sp1 - n) : sp1[Ib-1:0];
         s1_in.ix3 = (sp2 >= n) ? Ib'(sp2 - n) : sp2[Ib-1:0];
      end else begin
         s1_in.ix0 = (seg == '0) ? '0 : seg - Ib'(1);
         s1_in.ix2 = sp1[Ib-1:0];
         s1_in.ix3 = (sp2 > n - Cb'(1)) ? Ib'(n - Cb'(1)) : sp2[Ib-1:0];
      end
      s1_in.t = t;
      if (n < Cb'(2)) begin
         s1_in.few    = 1'b1;
         s1_in.one_pt = (n == Cb'(1));
         s1_in.status = crps_pkg::StatFew;
         s1_in.ix0    = '0;
      end
   end

   // t squared, rounded half up
   always_comb begin
      sq    = s1_ff.t * s1_ff.t + (2*Tb)'(1 << (Fb-1));
      s2_in = s1_ff;
      s2_in.tt = sq[Fb+Tb-1:Fb];
   end

   // t cubed, rounded half up
   always_comb begin
      cube  = s2_ff.tt * s2_ff.t + (2*Tb)'(1 << (Fb-1));
      s3_in = s2_ff;
      s3_in.ttt = cube[Fb+Tb-1:Fb];
   end

   // valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req.valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   // payload chain
   always_ff @(posedge clock) begin
      if (advance) begin
         s1_ff <= s1_in;
         s2_ff <= s2_in;
         s3_ff <= s3_in;
      end
   end

endmodule
`default_nettype wire

>>> rtl/crps_queue.sv
// crps_queue: short fifo of words between front and back
`timescale 1ns / 1ps
`default_nettype none
module crps_queue (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     push_valid,
   input  crps_pkg::crps_word_type push_word,
   output logic                    push_ready,
   output logic                    pop_valid,
   output crps_pkg::crps_word_type pop_word,
   input  wire                     pop_ready
);

   localparam int Pb = crps_pkg::QPtrBits;

   crps_pkg::crps_word_type slots_ff [crps_pkg::QueueDepth];
   logic [Pb-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [Pb:0]   fill_ff;
   logic          do_push, do_pop;

   assign push_ready = (fill_ff != (Pb+1)'(crps_pkg::QueueDepth));
   assign pop_valid  = (fill_ff != '0);
   assign pop_word   = slots_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // pointers and fill
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         if (do_push) wr_ptr_ff <= wr_ptr_ff + Pb'(1);
         if (do_pop)  rd_ptr_ff <= rd_ptr_ff + Pb'(1);
         fill_ff <= fill_ff + (Pb+1)'(do_push) - (Pb+1)'(do_pop);
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) slots_ff[wr_ptr_ff] <= push_word;
   end

endmodule
`default_nettype wire

>>> rtl/crps_back.sv
// crps_back: point table, weights, products, sums and rounding to the response
`timescale 1ns / 1ps
`default_nettype none
module crps_back (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     word_valid,
   input  crps_pkg::crps_word_type word,
   output logic                    word_ready,
   crps_rsp_if.source              rsp
);

   localparam int Cw = crps_pkg::CoordBits;
   localparam int Wb = crps_pkg::WeightBits;
   localparam int Pb = crps_pkg::ProdBits;
   localparam int Ab = crps_pkg::AccBits;
   localparam int Fb = crps_pkg::FracBits;
   localparam int Ib = crps_pkg::IdxBits;

   typedef logic signed [Wb-1:0] weight_type;
   typedef logic signed [Pb-1:0] prod_type;
   typedef logic signed [Ab-1:0] acc_type;

   localparam weight_type One = weight_type'(1 << Fb);

   logic enable, pop;
   logic [Ib-1:0] ix [4];

   // four table copies, one read port each
   logic [2*Cw-1:0] mem0 [crps_pkg::MaxPoints];
   logic [2*Cw-1:0] mem1 [crps_pkg::MaxPoints];
   logic [2*Cw-1:0] mem2 [crps_pkg::MaxPoints];
   logic [2*Cw-1:0] mem3 [crps_pkg::MaxPoints];
   logic [2*Cw-1:0] rd_ff [4];

   logic       b1_valid_ff, b2_valid_ff, b3_valid_ff, out_valid_ff;
   logic       b1_few_ff, b1_one_ff, b2_few_ff, b3_few_ff;
   logic [1:0] b1_stat_ff, b2_stat_ff, b3_stat_ff;
   weight_type wp_ff [4], wd_ff [4], wp_in [4], wd_in [4];
   prod_type   pxp_ff [4], pyp_ff [4], pxd_ff [4], pyd_ff [4];
   acc_type    acc_ff [4];
   logic signed [Cw-1:0] fx2_ff, fy2_ff, fx3_ff, fy3_ff;
   logic signed [Cw-1:0] res_ff [4];
   logic [1:0] out_stat_ff;

   assign enable     = !out_valid_ff || rsp.ready;
   assign word_ready = enable;
   assign pop        = word_valid && enable;
   assign ix[0] = word.ix0;
   assign ix[1] = word.ix1;
   assign ix[2] = word.ix2;
   assign ix[3] = word.ix3;

   // round half up, drop fraction, saturate
   function automatic logic signed [Cw-1:0] round_sat(input acc_type a);
      acc_type r;
      r = (a + acc_type'(1 << Fb)) >>> (Fb + 1);
      if (r > acc_type'(2147483647))
         return {1'b0, {(Cw-1){1'b1}}};
      else if (r < acc_type'(-64'sd2147483648))
         return {1'b1, {(Cw-1){1'b0}}};
      else
         return r[Cw-1:0];
   endfunction

   // table writes and registered reads
   always_ff @(posedge clock) begin
      if (pop && word.is_load) begin
         mem0[word.slot] <= {word.px, word.py};
         mem1[word.slot] <= {word.px, word.py};
         mem2[word.slot] <= {word.px, word.py};
         mem3[word.slot] <= {word.px, word.py};
      end
      if (enable) begin
         rd_ff[0] <= mem0[ix[0]];
         rd_ff[1] <= mem1[ix[1]];
         rd_ff[2] <= mem2[ix[2]];
         rd_ff[3] <= mem3[ix[3]];
      end
   end

   // blending weights for point and slope
   always_comb begin
      weight_type t, tt, ttt;
      t   = weight_type'(word.t);
      tt  = weight_type'(word.tt);
      ttt = weight_type'(word.ttt);
      wp_in[0] = weight_type'(-ttt + 2*tt - t);
      wp_in[1] = weight_type'(3*ttt - 5*tt + 2*One);
      wp_in[2] = weight_type'(-3*ttt + 4*tt + t);
      wp_in[3] = weight_type'(ttt - tt);
      wd_in[0] = weight_type'(-3*tt + 4*t - One);
      wd_in[1] = weight_type'(9*tt - 10*t);
      wd_in[2] = weight_type'(-9*tt + 8*t + One);
      wd_in[3] = weight_type'(3*tt - 2*t);
   end

   // valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         b1_valid_ff  <= 1'b0;
         b2_valid_ff  <= 1'b0;
         b3_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (enable) begin
         b1_valid_ff  <= pop && !word.is_load;
         b2_valid_ff  <= b1_valid_ff;
         b3_valid_ff  <= b2_valid_ff;
         out_valid_ff <= b3_valid_ff;
      end
   end

   // datapath stages
   always_ff @(posedge clock) begin
      if (enable) begin
         wp_ff      <= wp_in;
         wd_ff      <= wd_in;
         b1_few_ff  <= word.few;
         b1_one_ff  <= word.one_pt;
         b1_stat_ff <= word.status;
         for (int k = 0; k < 4; k++) begin
            pxp_ff[k] <= prod_type'($signed(rd_ff[k][2*Cw-1:Cw])) * prod_type'(wp_ff[k]);
            pyp_ff[k] <= prod_type'($signed(rd_ff[k][Cw-1:0])) * prod_type'(wp_ff[k]);
            pxd_ff[k] <= prod_type'($signed(rd_ff[k][2*Cw-1:Cw])) * prod_type'(wd_ff[k]);
            pyd_ff[k] <= prod_type'($signed(rd_ff[k][Cw-1:0])) * prod_type'(wd_ff[k]);
         end
         fx2_ff     <= b1_one_ff ? $signed(rd_ff[0][2*Cw-1:Cw]) : '0;
         fy2_ff     <= b1_one_ff ? $signed(rd_ff[0][Cw-1:0]) : '0;
         b2_few_ff  <= b1_few_ff;
         b2_stat_ff <= b1_stat_ff;
         acc_ff[0]  <= acc_type'(pxp_ff[0]) + acc_type'(pxp_ff[1])
                     + acc_type'(pxp_ff[2]) + acc_type'(pxp_ff[3]);
         acc_ff[1]  <= acc_type'(pyp_ff[0]) + acc_type'(pyp_ff[1])
                     + acc_type'(pyp_ff[2]) + acc_type'(pyp_ff[3]);
         acc_ff[2]  <= acc_type'(pxd_ff[0]) + acc_type'(pxd_ff[1])
                     + acc_type'(pxd_ff[2]) + acc_type'(pxd_ff[3]);
         acc_ff[3]  <= acc_type'(pyd_ff[0]) + acc_type'(pyd_ff[1])
                     + acc_type'(pyd_ff[2]) + acc_type'(pyd_ff[3]);
         fx3_ff     <= fx2_ff;
         fy3_ff     <= fy2_ff;
         b3_few_ff  <= b2_few_ff;
         b3_stat_ff <= b2_stat_ff;
         res_ff[0]  <= b3_few_ff ? fx3_ff : round_sat(acc_ff[0]);
         res_ff[1]  <= b3_few_ff ? fy3_ff : round_sat(acc_ff[1]);
         res_ff[2]  <= b3_few_ff ? '0 : round_sat(acc_ff[2]);
         res_ff[3]  <= b3_few_ff ? '0 : round_sat(acc_ff[3]);
         out_stat_ff <= b3_stat_ff;
      end
   end

   assign rsp.valid   = out_valid_ff;
   assign rsp.curve_x = res_ff[0];
   assign rsp.curve_y = res_ff[1];
   assign rsp.slope_x = res_ff[2];
   assign rsp.slope_y = res_ff[3];
   assign rsp.status  = out_stat_ff;

endmodule
`default_nettype wire

>>> rtl/catmull_rom_point_and_slope_core.sv
// catmull_rom_point_and_slope_core: top level with csr registers, front, queue, back
//
//   channel  dir  word
//   req_chan in   load point or evaluate position
//   rsp_chan out  curve point, slope, status (evaluates only)
//   csr_chan in   register index and data, always ready
//
// one word per cycle sustained while the response is not stalled; an evaluate
// result passes 8 register stages, the first loaded on its accepting edge: 3
// front stages, queue, read, multiply, sum, round/saturate.
// the four-port point read uses four table copies written together.
// reset clears control state only; the point table is unset until loaded.
// a stalled response holds the back end; the 4-word queue absorbs the front.
`timescale 1ns / 1ps
`default_nettype none
module catmull_rom_point_and_slope_core (
   input  wire         clock,
   input  wire         reset,
   crps_req_if.sink    req_chan,
   crps_rsp_if.source  rsp_chan,
   crps_csr_if.sink    csr_chan
);

   crps_pkg::crps_cfg_type  cfg_ff;
   crps_pkg::crps_word_type f_word, q_word;
   logic f_valid, f_ready, q_valid, q_ready;

   assign csr_chan.ready = 1'b1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_chan.valid) begin
         case (csr_chan.index)
            crps_pkg::CsrClosedMode: cfg_ff.closed <= csr_chan.data[0];
            crps_pkg::CsrPointCount: cfg_ff.count  <= csr_chan.data;
            default: ;
         endcase
      end
   end

   crps_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_chan),
      .cfg        (cfg_ff),
      .word_valid (f_valid),
      .word       (f_word),
      .word_ready (f_ready)
   );

   crps_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (f_valid),
      .push_word  (f_word),
      .push_ready (f_ready),
      .pop_valid  (q_valid),
      .pop_word   (q_word),
      .pop_ready  (q_ready)
   );

   crps_back u_back (
      .clock      (clock),
      .reset      (reset),
      .word_valid (q_valid),
      .word       (q_word),
      .word_ready (q_ready),
      .rsp        (rsp_chan)
   );

endmodule
`default_nettype wire
